### rtl/core/asp_pkg.sv
// ----------------------------------------------------------------------------
// asp_pkg
// Register widths, reset values, register indexes and polarity codes of the
// adaptive spike suppressor.
// ----------------------------------------------------------------------------
package asp_pkg;

  localparam int DELAY_LEN_W = 7;
  localparam int STEP_W      = 8;
  localparam int FLOOR_W     = 9;
  localparam int CUTOFF_W    = 13;
  localparam int HOLD_W      = 17;
  localparam int THRESH_W    = 31;
  localparam int FILL_W      = 7;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 31;

  localparam logic [DELAY_LEN_W-1:0] DELAY_LEN_RST = DELAY_LEN_W'(2);
  localparam logic [STEP_W-1:0]      STEP_RST      = STEP_W'(4);
  localparam logic [FLOOR_W-1:0]     FLOOR_RST     = FLOOR_W'(8);
  localparam logic [CUTOFF_W-1:0]    CEILING_RST   = CUTOFF_W'(200);
  localparam logic [HOLD_W-1:0]      HOLDOFF_RST   = HOLD_W'(400);
  localparam logic [THRESH_W-1:0]    THRESH_RST    = THRESH_W'(1000);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELAY_LENGTH    = 3'd0,
    CFG_STEP_SAMPLES    = 3'd1,
    CFG_CUTOFF_FLOOR    = 3'd2,
    CFG_CUTOFF_CEILING  = 3'd3,
    CFG_HOLDOFF_SAMPLES = 3'd4,
    CFG_THRESHOLD       = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    POL_NONE = 2'd0,
    POL_POS  = 2'd1,
    POL_NEG  = 2'd2
  } polarity_e;

endpackage

### rtl/core/asp_if.sv
// ----------------------------------------------------------------------------
// asp_if
// Stream channels of the spike suppressor: input word and result word.
// ----------------------------------------------------------------------------
interface asp_in_if #(
  parameter int SAMPLE_WIDTH = 32
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface asp_out_if #(
  parameter int SAMPLE_WIDTH = 32
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;
  logic                           spike_detected;
  logic                           suppressing;

  modport source (output valid, output sample_out, output spike_detected,
                  output suppressing, input ready);
  modport sink   (input valid, input sample_out, input spike_detected,
                  input suppressing, output ready);
endinterface

### rtl/core/asp_cell.sv
// ----------------------------------------------------------------------------
// asp_cell
// One ring slot: holds a sample, takes the write at its own index and puts
// its sample on the read chain when selected, else passes the neighbour on.
// ----------------------------------------------------------------------------
module asp_cell #(
  parameter int SAMPLE_WIDTH = 32,
  parameter int PTR_W        = 6,
  parameter int IDX          = 0
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    wr_en_i,
  input  logic [PTR_W-1:0]        wr_ptr_i,
  input  logic [PTR_W-1:0]        rd_ptr_i,
  input  logic [SAMPLE_WIDTH-1:0] wr_data_i,
  input  logic [SAMPLE_WIDTH-1:0] rd_i,
  output logic [SAMPLE_WIDTH-1:0] rd_o
);

  logic [SAMPLE_WIDTH-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (wr_en_i && (wr_ptr_i == PTR_W'(IDX))) begin
      data_d = wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else begin
      data_q <= data_d;
    end
  end

  assign rd_o = (rd_ptr_i == PTR_W'(IDX)) ? data_q : rd_i;

endmodule

### rtl/core/asp_ring.sv
// ----------------------------------------------------------------------------
// asp_ring
// Row of ring cells joined by a read chain; one write and one read per cycle.
// ----------------------------------------------------------------------------
module asp_ring #(
  parameter int SAMPLE_WIDTH = 32,
  parameter int MAX_DELAY    = 64,
  parameter int PTR_W        = 6
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    wr_en_i,
  input  logic [PTR_W-1:0]        wr_ptr_i,
  input  logic [PTR_W-1:0]        rd_ptr_i,
  input  logic [SAMPLE_WIDTH-1:0] wr_data_i,
  output logic [SAMPLE_WIDTH-1:0] rd_data_o
);

  logic [SAMPLE_WIDTH-1:0] rd_chain [MAX_DELAY+1];

  assign rd_chain[0] = '0;

  for (genvar g = 0; g < MAX_DELAY; g++) begin : g_cell
    asp_cell #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .PTR_W        (PTR_W),
      .IDX          (g)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .wr_en_i   (wr_en_i),
      .wr_ptr_i  (wr_ptr_i),
      .rd_ptr_i  (rd_ptr_i),
      .wr_data_i (wr_data_i),
      .rd_i      (rd_chain[g]),
      .rd_o      (rd_chain[g+1])
    );
  end

  assign rd_data_o = rd_chain[MAX_DELAY];

endmodule

### rtl/core/adaptive_spike_suppressor.sv
// ----------------------------------------------------------------------------
// adaptive_spike_suppressor
// Delays a sample stream through a ring of cells, detects spikes against the
// oldest sample and replaces them by a latched baseline for an adaptive time.
// The result word is registered in the cycle after its input word is taken.
// Throughput: one word per cycle while the receiver takes results; the ring read runs along the row of
// MAX_DELAY cells and the next slot is fetched while the current one is written.
// Reset clears the ring, pointer, counters and baseline and loads register
// defaults; the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module adaptive_spike_suppressor #(
  parameter int MAX_DELAY    = 64,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [asp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [asp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  asp_in_if.sink                        in_i,
  asp_out_if.source                     out_o
);

  import asp_pkg::*;

  localparam int PTR_W  = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
  localparam int LEN_CW = ($clog2(MAX_DELAY + 1) > DELAY_LEN_W) ?
                          $clog2(MAX_DELAY + 1) : DELAY_LEN_W;
  localparam int MAG_W  = (SAMPLE_WIDTH > THRESH_W) ? SAMPLE_WIDTH : THRESH_W;
  localparam int ELAP_W = CUTOFF_W + 2;

  // configuration
  logic [DELAY_LEN_W-1:0] delay_len_q;
  logic [STEP_W-1:0]      step_q;
  logic [FLOOR_W-1:0]     floor_q;
  logic [CUTOFF_W-1:0]    ceiling_q;
  logic [HOLD_W-1:0]      holdoff_q;
  logic [THRESH_W-1:0]    thresh_q;

  // state
  logic [PTR_W-1:0]        ptr_q, ptr_d;
  logic [FILL_W-1:0]       fill_q, fill_d;
  logic [CUTOFF_W-1:0]     cut_q, cut_d;
  logic [HOLD_W-1:0]       hold_q, hold_d;
  logic [CUTOFF_W-1:0]     len_q, len_d;
  polarity_e               pol_q, pol_d;
  logic                    flank_seen_q, flank_seen_d;
  logic [SAMPLE_WIDTH-1:0] base_q, base_d;
  logic [SAMPLE_WIDTH-1:0] old_q, old_d;

  // result word
  logic                    out_valid_q, out_valid_d;
  logic [SAMPLE_WIDTH-1:0] out_sample_q, out_sample_d;
  logic                    out_det_q, out_det_d;
  logic                    out_supp_q, out_supp_d;

  logic                    in_ready;
  logic                    accept;
  logic [SAMPLE_WIDTH-1:0] x;
  logic [SAMPLE_WIDTH-1:0] rd_data;
  logic [LEN_CW-1:0]       eff_len;
  logic [LEN_CW-1:0]       ptr_inc;
  logic [PTR_W-1:0]        ptr_next;
  logic                    run_in;
  logic signed [SAMPLE_WIDTH:0] diff;
  logic [SAMPLE_WIDTH-1:0] abs_diff;
  logic [MAG_W-1:0]        mag;
  logic                    det;
  polarity_e               pol;
  logic                    flank;
  logic signed [ELAP_W-1:0] elapsed;
  logic [CUTOFF_W:0]       grown;

  assign x        = in_i.sample_in;
  assign in_ready = !out_valid_q || out_o.ready;
  assign accept   = in_i.valid && in_ready;

  // effective ring length and pointer advance
  always_comb begin
    if (LEN_CW'(delay_len_q) < LEN_CW'(2)) begin
      eff_len = LEN_CW'(2);
    end else if (LEN_CW'(delay_len_q) > LEN_CW'(MAX_DELAY)) begin
      eff_len = LEN_CW'(MAX_DELAY);
    end else begin
      eff_len = LEN_CW'(delay_len_q);
    end
    ptr_inc  = LEN_CW'(ptr_q) + LEN_CW'(1);
    ptr_next = (ptr_inc >= eff_len) ? '0 : PTR_W'(ptr_inc);
    run_in   = LEN_CW'(fill_q) < eff_len;
  end

  asp_ring #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .MAX_DELAY    (MAX_DELAY),
    .PTR_W        (PTR_W)
  ) u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (accept),
    .wr_ptr_i  (ptr_q),
    .rd_ptr_i  (ptr_next),
    .wr_data_i (x),
    .rd_data_o (rd_data)
  );

  // spike test against the oldest sample
  always_comb begin
    diff     = $signed({x[SAMPLE_WIDTH-1], x}) - $signed({old_q[SAMPLE_WIDTH-1], old_q});
    abs_diff = diff[SAMPLE_WIDTH] ? SAMPLE_WIDTH'(-diff) : SAMPLE_WIDTH'(diff);
    mag      = MAG_W'(abs_diff);
    det      = mag > MAG_W'(thresh_q);
    pol      = diff[SAMPLE_WIDTH] ? POL_NEG : POL_POS;
    flank    = det && (pol != pol_q) && !flank_seen_q;
  end

  // item update
  always_comb begin
    ptr_d        = ptr_q;
    fill_d       = fill_q;
    cut_d        = cut_q;
    hold_d       = hold_q;
    len_d        = len_q;
    pol_d        = pol_q;
    flank_seen_d = flank_seen_q;
    base_d       = base_q;
    old_d        = old_q;
    out_sample_d = out_sample_q;
    out_det_d    = out_det_q;
    out_supp_d   = out_supp_q;
    elapsed      = '0;
    grown        = '0;

    if (accept) begin
      ptr_d      = ptr_next;
      old_d      = rd_data;
      out_det_d  = 1'b0;
      out_supp_d = 1'b0;
      if (run_in) begin
        fill_d       = fill_q + 1'b1;
        out_sample_d = x;
      end else if (cut_q != '0) begin
        cut_d = cut_q - 1'b1;
        if (hold_q != '0) begin
          hold_d = hold_q - 1'b1;
        end
        elapsed = $signed({2'b00, len_q}) - $signed({2'b00, cut_d});
        if (flank && (len_q > CUTOFF_W'(floor_q)) &&
            (elapsed > $signed(ELAP_W'(step_q)))) begin
          len_d        = (len_q > CUTOFF_W'(step_q)) ? (len_q - CUTOFF_W'(step_q)) : '0;
          flank_seen_d = 1'b1;
        end
        out_sample_d = base_q;
        out_supp_d   = 1'b1;
      end else if (hold_q != '0) begin
        hold_d = hold_q - 1'b1;
        if (flank) begin
          grown = {1'b0, len_q} + (CUTOFF_W + 1)'(step_q);
          if (grown > {1'b0, ceiling_q}) begin
            grown = {1'b0, ceiling_q};
          end
          len_d        = grown[CUTOFF_W-1:0];
          flank_seen_d = 1'b1;
        end
        out_sample_d = rd_data;
      end else if (det) begin
        base_d       = old_q;
        hold_d       = holdoff_q;
        cut_d        = len_q;
        pol_d        = pol;
        flank_seen_d = 1'b0;
        out_sample_d = old_q;
        out_det_d    = 1'b1;
        out_supp_d   = 1'b1;
      end else begin
        out_sample_d = rd_data;
      end
    end

    // a new step size also restarts the cutoff length
    if (cfg_we_i && (cfg_idx_e'(cfg_idx_i) == CFG_STEP_SAMPLES)) begin
      len_d = CUTOFF_W'(cfg_data_i[STEP_W-1:0]);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_len_q <= DELAY_LEN_RST;
      step_q      <= STEP_RST;
      floor_q     <= FLOOR_RST;
      ceiling_q   <= CEILING_RST;
      holdoff_q   <= HOLDOFF_RST;
      thresh_q    <= THRESH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_DELAY_LENGTH:    delay_len_q <= cfg_data_i[DELAY_LEN_W-1:0];
        CFG_STEP_SAMPLES:    step_q      <= cfg_data_i[STEP_W-1:0];
        CFG_CUTOFF_FLOOR:    floor_q     <= cfg_data_i[FLOOR_W-1:0];
        CFG_CUTOFF_CEILING:  ceiling_q   <= cfg_data_i[CUTOFF_W-1:0];
        CFG_HOLDOFF_SAMPLES: holdoff_q   <= cfg_data_i[HOLD_W-1:0];
        CFG_THRESHOLD:       thresh_q    <= cfg_data_i[THRESH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q        <= '0;
      fill_q       <= '0;
      cut_q        <= '0;
      hold_q       <= '0;
      len_q        <= CUTOFF_W'(STEP_RST);
      pol_q        <= POL_NONE;
      flank_seen_q <= 1'b0;
      base_q       <= '0;
      old_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      ptr_q        <= ptr_d;
      fill_q       <= fill_d;
      cut_q        <= cut_d;
      hold_q       <= hold_d;
      len_q        <= len_d;
      pol_q        <= pol_d;
      flank_seen_q <= flank_seen_d;
      base_q       <= base_d;
      old_q        <= old_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_sample_q <= out_sample_d;
    out_det_q    <= out_det_d;
    out_supp_q   <= out_supp_d;
  end

  assign in_i.ready           = in_ready;
  assign out_o.valid          = out_valid_q;
  assign out_o.sample_out     = out_sample_q;
  assign out_o.spike_detected = out_det_q;
  assign out_o.suppressing    = out_supp_q;

endmodule

### sim/tb_adaptive_spike_suppressor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_adaptive_spike_suppressor
// Streams signed samples through the spike suppressor under a series of
// register settings and checks every result word against a cycle-free
// prediction of the delay ring, spike detection, baseline replacement and
// cutoff adaptation. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_adaptive_spike_suppressor;
  import asp_pkg::*;

  localparam int DEPTH = 64;
  localparam int SW    = 32;

  typedef logic [SW-1:0] word_t;

  typedef struct packed {
    word_t smp;
    logic  det;
    logic  sup;
  } result_t;

  typedef struct {
    int unsigned dly;
    int unsigned step;
    int unsigned flo;
    int unsigned cei;
    int unsigned hold;
    int unsigned thr;
    int unsigned items;
    bit          steady;
  } plan_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  asp_in_if  #(.SAMPLE_WIDTH(SW)) in_bus ();
  asp_out_if #(.SAMPLE_WIDTH(SW)) out_bus ();

  adaptive_spike_suppressor #(
    .MAX_DELAY   (DEPTH),
    .SAMPLE_WIDTH(SW)
  ) uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (in_bus),
    .out_o     (out_bus)
  );

  // register copy
  logic [DELAY_LEN_W-1:0] k_delay;
  logic [STEP_W-1:0]      k_step;
  logic [FLOOR_W-1:0]     k_floor;
  logic [CUTOFF_W-1:0]    k_ceil;
  logic [HOLD_W-1:0]      k_hold;
  logic [THRESH_W-1:0]    k_thresh;

  // predicted block state
  word_t               ring_m [DEPTH];
  int unsigned         ptr_m;
  logic [FILL_W-1:0]   fill_m;
  logic [CUTOFF_W-1:0] cut_cnt_m;
  logic [CUTOFF_W-1:0] cut_len_m;
  logic [HOLD_W-1:0]   hold_cnt_m;
  polarity_e           pol_m;
  bit                  flank_m;
  word_t               base_m;

  word_t       raw_q [$];
  result_t     cleaned_q [$];
  word_t       rim_words [4] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF};

  bit          took_word;
  bit          steady_send;
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned rdy_left;
  logic [15:0] rdy_pat;

  int unsigned errors;
  int unsigned words_in;
  int unsigned words_out;
  int unsigned spikes_seen;
  int unsigned replaced;
  int unsigned phases_run;

  function automatic int unsigned ring_len();
    if (k_delay < 2) return 2;
    if (k_delay > DEPTH) return DEPTH;
    return k_delay;
  endfunction

  function automatic void ring_push(word_t x);
    int unsigned nxt;
    nxt = ptr_m + 1;
    ring_m[ptr_m % DEPTH] = x;
    if (nxt >= ring_len()) nxt = 0;
    ptr_m = nxt % DEPTH;
  endfunction

  function automatic void clear_model();
    k_delay    = DELAY_LEN_RST;
    k_step     = STEP_RST;
    k_floor    = FLOOR_RST;
    k_ceil     = CEILING_RST;
    k_hold     = HOLDOFF_RST;
    k_thresh   = THRESH_RST;
    foreach (ring_m[i]) ring_m[i] = '0;
    ptr_m      = 0;
    fill_m     = '0;
    cut_cnt_m  = '0;
    hold_cnt_m = '0;
    cut_len_m  = CUTOFF_W'(STEP_RST);
    pol_m      = POL_NONE;
    flank_m    = 1'b0;
    base_m     = '0;
  endfunction

  function automatic void predict_cleaned(word_t x);
    word_t       old;
    longint      mag;
    longint      elapsed;
    polarity_e   pol;
    bit          det;
    bit          flank;
    int unsigned grown;
    result_t     r;
    old = ring_m[ptr_m % DEPTH];
    r   = '{smp: x, det: 1'b0, sup: 1'b0};
    if (fill_m < ring_len()) begin
      ring_push(x);
      fill_m = fill_m + 1'b1;
      cleaned_q.push_back(r);
      return;
    end
    if ($signed(x) < $signed(old)) begin
      mag = longint'($signed(old)) - longint'($signed(x));
      pol = POL_NEG;
    end else begin
      mag = longint'($signed(x)) - longint'($signed(old));
      pol = POL_POS;
    end
    det   = mag > longint'(k_thresh);
    flank = det && pol != pol_m && !flank_m;
    if (cut_cnt_m != 0) begin
      cut_cnt_m--;
      if (hold_cnt_m != 0) hold_cnt_m--;
      elapsed = longint'(cut_len_m) - longint'(cut_cnt_m);
      if (flank && cut_len_m > k_floor && elapsed > longint'(k_step)) begin
        cut_len_m = (cut_len_m > k_step) ? cut_len_m - k_step : '0;
        flank_m   = 1'b1;
      end
      ring_push(x);
      r.smp = base_m;
      r.sup = 1'b1;
    end else if (hold_cnt_m != 0) begin
      hold_cnt_m--;
      if (flank) begin
        grown = cut_len_m + k_step;
        if (grown > k_ceil) grown = k_ceil;
        cut_len_m = CUTOFF_W'(grown);
        flank_m   = 1'b1;
      end
      ring_push(x);
      r.smp = ring_m[ptr_m];
    end else if (det) begin
      base_m     = old;
      hold_cnt_m = k_hold;
      cut_cnt_m  = cut_len_m;
      pol_m      = pol;
      flank_m    = 1'b0;
      ring_push(x);
      r = '{smp: old, det: 1'b1, sup: 1'b1};
    end else begin
      ring_push(x);
      r.smp = ring_m[ptr_m];
    end
    cleaned_q.push_back(r);
  endfunction

  task automatic write_knob(cfg_idx_e idx, int unsigned val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CFG_DATA_W'(val);
    case (idx)
      CFG_DELAY_LENGTH:    k_delay  = DELAY_LEN_W'(val);
      CFG_STEP_SAMPLES: begin
        k_step    = STEP_W'(val);
        cut_len_m = CUTOFF_W'(k_step);
      end
      CFG_CUTOFF_FLOOR:    k_floor  = FLOOR_W'(val);
      CFG_CUTOFF_CEILING:  k_ceil   = CUTOFF_W'(val);
      CFG_HOLDOFF_SAMPLES: k_hold   = HOLD_W'(val);
      CFG_THRESHOLD:       k_thresh = THRESH_W'(val);
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic apply_plan(plan_t p, bit all);
    if (all || p.dly != k_delay) write_knob(CFG_DELAY_LENGTH, p.dly);
    if (all || p.step != k_step) write_knob(CFG_STEP_SAMPLES, p.step);
    if (all || p.flo != k_floor) write_knob(CFG_CUTOFF_FLOOR, p.flo);
    if (all || p.cei != k_ceil) write_knob(CFG_CUTOFF_CEILING, p.cei);
    if (all || p.hold != k_hold) write_knob(CFG_HOLDOFF_SAMPLES, p.hold);
    if (all || p.thr != k_thresh) write_knob(CFG_THRESHOLD, p.thr);
  endtask

  // quiet level with noise, mono- and biphasic spikes, drift and raw noise words
  task automatic add_signal(int unsigned n, int unsigned thr);
    int unsigned k;
    int unsigned r;
    int unsigned len;
    int unsigned j;
    int unsigned nz;
    int unsigned swing;
    longint      lvl;
    longint      amp;
    longint      v;
    bit          flip;
    nz = (thr / 4 < 4000) ? thr / 4 : 4000;
    if ($urandom_range(0, 4) == 0) nz = 0;
    lvl = ($urandom_range(0, 1) == 0) ? longint'($signed($urandom))
                                      : longint'($urandom_range(0, 2000)) - 1000;
    k = 0;
    while (k < n) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        if ($urandom_range(0, 3) == 0) raw_q.push_back(rim_words[$urandom_range(0, 3)]);
        else raw_q.push_back(word_t'($urandom));
        k++;
      end else if (r < 19) begin
        swing = (thr < 1000) ? thr : 1000;
        amp   = longint'(thr) + 1 + longint'($urandom_range(0, swing));
        // amplitude right on the threshold
        if ($urandom_range(0, 3) == 0) amp = longint'(thr);
        if ($urandom_range(0, 1) == 1) amp = -amp;
        len  = $urandom_range(1, 3);
        flip = $urandom_range(0, 1);
        for (j = 0; j < len; j++) raw_q.push_back(word_t'(lvl + amp));
        if (flip) for (j = 0; j < len; j++) raw_q.push_back(word_t'(lvl - amp));
        k += flip ? 2 * len : len;
      end else if (r < 21) begin
        lvl = lvl + longint'($urandom_range(0, 2 * nz + 2)) - longint'(nz + 1);
        raw_q.push_back(word_t'(lvl));
        k++;
      end else begin
        v = (nz == 0) ? lvl : lvl + longint'($urandom_range(0, 2 * nz)) - longint'(nz);
        raw_q.push_back(word_t'(v));
        k++;
      end
    end
  endtask

  task automatic wait_drained();
    while (raw_q.size() != 0 || cleaned_q.size() != 0 || in_bus.valid) @(posedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  // sender: bursts with gaps in between, no gaps when steady
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || took_word) begin
      if (gap_left > 0) begin
        in_bus.valid <= 1'b0;
        gap_left--;
      end else if (raw_q.size() > 0) begin
        in_bus.valid     <= 1'b1;
        in_bus.sample_in <= raw_q.pop_front();
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 32);
          if (steady_send || $urandom_range(0, 3) == 0) gap_left = 0;
          else gap_left = $urandom_range(1, 6);
        end
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // receiver: rotating stall pattern, redrawn now and then
  always @(negedge clk_i) begin
    if (rdy_left == 0) begin
      rdy_left = $urandom_range(16, 96);
      if ($urandom_range(0, 2) == 0) rdy_pat = '1;
      else rdy_pat = 16'($urandom | $urandom) | 16'd1;
    end else begin
      rdy_left--;
    end
    rdy_pat = {rdy_pat[0], rdy_pat[15:1]};
    out_bus.ready <= rdy_pat[0];
  end

  always @(posedge clk_i) begin
    result_t want;
    took_word = 1'b0;
    if (rst_ni) begin
      if (in_bus.valid && in_bus.ready) begin
        took_word = 1'b1;
        predict_cleaned(in_bus.sample_in);
        words_in++;
      end
      if (out_bus.valid && out_bus.ready) begin
        words_out++;
        spikes_seen += out_bus.spike_detected;
        replaced    += out_bus.suppressing;
        if (cleaned_q.size() == 0) begin
          errors++;
          if (errors <= 40)
            $display("%0t: unexpected word out=%h det=%b sup=%b", $time,
                     out_bus.sample_out, out_bus.spike_detected, out_bus.suppressing);
        end else begin
          want = cleaned_q.pop_front();
          if (out_bus.sample_out !== want.smp || out_bus.spike_detected !== want.det ||
              out_bus.suppressing !== want.sup) begin
            errors++;
            if (errors <= 40)
              $display("%0t: word %0d expected out=%h det=%b sup=%b, got out=%h det=%b sup=%b",
                       $time, words_out, want.smp, want.det, want.sup, out_bus.sample_out,
                       out_bus.spike_detected, out_bus.suppressing);
          end
        end
      end
    end
  end

  initial begin
    plan_t plan [12];
    word_t opening [$];
    int unsigned i;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = CFG_DELAY_LENGTH;
    cfg_data_i       = '0;
    in_bus.valid     = 1'b0;
    in_bus.sample_in = '0;
    out_bus.ready    = 1'b0;
    took_word        = 1'b0;
    steady_send      = 1'b0;
    burst_left       = 1;
    gap_left         = 0;
    rdy_left         = 0;
    rdy_pat          = '1;
    errors           = 0;
    words_in         = 0;
    words_out        = 0;
    spikes_seen      = 0;
    replaced         = 0;
    phases_run       = 0;
    clear_model();

    //          delay step floor ceil  hold    threshold    items steady
    plan[0]  = '{8,   4,   8,    200,  40,     1000,        200,  0};
    plan[1]  = '{16,  6,   8,    200,  60,     500,         150,  1};
    plan[2]  = '{2,   4,   8,    200,  40,     0,           120,  0};
    plan[3]  = '{0,   5,   8,    200,  40,     300,         60,   0};
    plan[4]  = '{1,   5,   8,    200,  40,     300,         60,   0};
    plan[5]  = '{127, 8,   10,   250,  40,     800,         100,  1};
    plan[6]  = '{65,  8,   10,   250,  40,     800,         60,   0};
    plan[7]  = '{30,  0,   8,    200,  40,     1500,        80,   0};
    plan[8]  = '{12,  10,  20,   300,  45,     2000,        200,  0};
    plan[9]  = '{5,   20,  8,    6400, 100,    100000,      120,  0};
    plan[10] = '{40,  16,  8,    1000, 50,     5000,        100,  0};
    plan[11] = '{64,  128, 256,  6400, 128000, 32'h7FFF_FFFF, 100, 0};

    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings apart from a short holdoff
    write_knob(CFG_HOLDOFF_SAMPLES, 40);
    opening = '{32'd0, 32'd0, 32'd0, 32'd1000, 32'd500, 32'hFFFF_FFFF,
                32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000,
                32'h5555_5555, 32'hAAAA_AAAA, 32'h7FFF_FFFF, 32'h8000_0000,
                32'd1001, 32'hFFFF_FC17, 32'd0, 32'd0};
    foreach (opening[j]) raw_q.push_back(opening[j]);
    wait_drained();
    phases_run++;

    for (i = 0; i < 12; i++) begin
      apply_plan(plan[i], i == 0);
      steady_send = plan[i].steady;
      add_signal(plan[i].items, plan[i].thr);
      wait_drained();
      phases_run++;
    end

    repeat (10) @(negedge clk_i);
    if (cleaned_q.size() != 0) begin
      errors += cleaned_q.size();
      $display("%0t: %0d expected words never arrived", $time, cleaned_q.size());
    end
    $display("covered %0d settings, %0d words in, %0d words out", phases_run, words_in,
             words_out);
    $display("spikes flagged %0d, words replaced by baseline %0d, mismatches %0d",
             spikes_seen, replaced, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
